// ===== rtl/stbs_pkg.sv =====
// Package for the sorted table binary search block.
// Table sizing, command and status structs, controller state type.
// No dependencies.
package stbs_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = IDX_W + 1;
    localparam int COUNT_W     = 6;
    localparam int KEY_W       = 16;
    localparam int VALUE_W     = 24;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_MISS
    } stbs_state_t;

    typedef struct packed {
        logic load_we;
        logic start;
        logic step;
        logic res_hit;
        logic res_miss;
    } stbs_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic more;
    } stbs_stat_t;

endpackage

// ===== rtl/stbs_datapath.sv =====
// Datapath: entry count register, key/value tables, search bounds and result register.
// Driven by stbs_ctrl through stbs_pkg::stbs_cmd_t; depends on stbs_pkg.
module stbs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  logic [stbs_pkg::IDX_W-1:0]          entry_index,
    input  logic [stbs_pkg::KEY_W-1:0]          entry_key,
    input  logic [stbs_pkg::VALUE_W-1:0]        entry_value,
    input  logic [stbs_pkg::KEY_W-1:0]          search_key,
    input  stbs_pkg::stbs_cmd_t                 cmd,
    output stbs_pkg::stbs_stat_t                stat,
    output logic                                found,
    output logic [stbs_pkg::IDX_W-1:0]          match_index,
    output logic [stbs_pkg::VALUE_W-1:0]        match_value
);

    localparam logic [stbs_pkg::BOUND_W-1:0] DEPTH_B = stbs_pkg::BOUND_W'(stbs_pkg::TABLE_DEPTH);

    logic [stbs_pkg::KEY_W-1:0]   key_mem [stbs_pkg::TABLE_DEPTH];
    logic [stbs_pkg::VALUE_W-1:0] val_mem [stbs_pkg::TABLE_DEPTH];

    logic [stbs_pkg::COUNT_W-1:0] entry_count_reg;
    logic [stbs_pkg::BOUND_W-1:0] low_reg, low_next;
    logic [stbs_pkg::BOUND_W-1:0] hi_reg, hi_next;
    logic [stbs_pkg::IDX_W-1:0]   mid_reg, mid_next;
    logic [stbs_pkg::KEY_W-1:0]   skey_reg;
    logic [stbs_pkg::KEY_W-1:0]   rd_key_reg;
    logic [stbs_pkg::VALUE_W-1:0] rd_val_reg;
    logic                         found_reg;
    logic [stbs_pkg::IDX_W-1:0]   index_reg;
    logic [stbs_pkg::VALUE_W-1:0] value_reg;

    logic [stbs_pkg::BOUND_W-1:0] count_c;
    logic [stbs_pkg::BOUND_W-1:0] count_m1;
    logic [stbs_pkg::BOUND_W-1:0] mid_ext;
    logic [stbs_pkg::BOUND_W:0]   sum_next;
    logic [stbs_pkg::IDX_W-1:0]   mid0;
    logic [stbs_pkg::IDX_W-1:0]   rd_addr;
    logic                         greater;

    // clamp count to table depth
    always_comb begin
        if (stbs_pkg::BOUND_W'(entry_count_reg) > DEPTH_B) begin
            count_c = DEPTH_B;
        end else begin
            count_c = stbs_pkg::BOUND_W'(entry_count_reg);
        end
        count_m1 = count_c - stbs_pkg::BOUND_W'(1);
        mid0     = count_m1[stbs_pkg::IDX_W:1];
    end

    // bounds kept as [low, hi) ; hi is one past the last candidate
    always_comb begin
        mid_ext = {1'b0, mid_reg};
        greater = rd_key_reg > skey_reg;
        if (greater) begin
            low_next = low_reg;
            hi_next  = mid_ext;
        end else begin
            low_next = mid_ext + stbs_pkg::BOUND_W'(1);
            hi_next  = hi_reg;
        end
        sum_next = {1'b0, low_next} + {1'b0, hi_next} - (stbs_pkg::BOUND_W+1)'(1);
        mid_next = sum_next[stbs_pkg::IDX_W:1];
        rd_addr  = cmd.start ? mid0 : mid_next;
    end

    assign stat.empty = (count_c == '0);
    assign stat.hit   = (rd_key_reg == skey_reg);
    assign stat.more  = (low_next < hi_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            key_mem[entry_index] <= entry_key;
            val_mem[entry_index] <= entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start || cmd.step) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            low_reg  <= '0;
            hi_reg   <= count_c;
            mid_reg  <= mid0;
            skey_reg <= search_key;
        end else if (cmd.step) begin
            low_reg <= low_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_hit) begin
            found_reg <= 1'b1;
            index_reg <= mid_reg;
            value_reg <= rd_val_reg;
        end else if (cmd.res_miss) begin
            found_reg <= 1'b0;
            index_reg <= '0;
            value_reg <= '0;
        end
    end

    assign found       = found_reg;
    assign match_index = index_reg;
    assign match_value = value_reg;

    // probed position always lies inside the live bounds
    a_mid_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start && !stat.empty) || (cmd.step && stat.more)
        |=> ({1'b0, mid_reg} >= low_reg) && ({1'b0, mid_reg} < hi_reg))
        else $error("probe index outside search bounds");

endmodule

// ===== rtl/stbs_ctrl.sv =====
// Controller: search sequencing and result valid flag.
// Commands stbs_datapath via stbs_pkg structs; depends on stbs_pkg.
module stbs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_kind,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  stbs_pkg::stbs_stat_t  stat,
    output stbs_pkg::stbs_cmd_t   cmd
);

    stbs_pkg::stbs_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;
    logic                  acc;

    assign out_free = !m_valid_reg || m_ready;
    assign acc      = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stbs_pkg::ST_IDLE: begin
                if (acc && s_kind == stbs_pkg::KIND_SEARCH) begin
                    state_next = stat.empty ? stbs_pkg::ST_MISS : stbs_pkg::ST_PROBE;
                end
            end
            stbs_pkg::ST_PROBE: begin
                if ((stat.hit || !stat.more) && out_free) begin
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            stbs_pkg::ST_MISS: begin
                if (out_free) begin
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            default: state_next = stbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            stbs_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_we = s_valid && s_kind == stbs_pkg::KIND_LOAD;
                cmd.start   = s_valid && s_kind == stbs_pkg::KIND_SEARCH;
            end
            stbs_pkg::ST_PROBE: begin
                if (stat.hit) begin
                    cmd.res_hit = out_free;
                end else if (!stat.more) begin
                    cmd.res_miss = out_free;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            stbs_pkg::ST_MISS: begin
                cmd.res_miss = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.res_hit || cmd.res_miss) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stbs_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_res_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.res_hit || cmd.res_miss) |-> out_free)
        else $error("result captured over a pending result");

    a_search_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !s_ready)
        else $error("input accepted during a search");

    a_hit_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stbs_pkg::ST_PROBE) && stat.hit && out_free |=> m_valid_reg)
        else $error("hit not presented as a result");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_we, cmd.start, cmd.step, cmd.res_hit, cmd.res_miss}))
        else $error("conflicting datapath commands");

endmodule

// ===== rtl/sorted_table_binary_search_top.sv =====
// Top level of the sorted table binary search block.
// Instantiates stbs_ctrl and stbs_datapath; depends on stbs_pkg.
//
//  channel   dir  tdata (low bit up)                                    tuser
//  s_axis    in   entry_index[4:0] entry_key[20:5] entry_value[44:21]   kind
//                 search_key[60:45] zero[63:61]
//  m_axis    out  match_index[4:0] match_value[28:5] zero[31:29]        found
//  cfg       in   cfg_wr_data = entry_count, written when cfg_wr_en
//
//  A load is written into the table when accepted. A search is accepted, then
//  probes until a hit or empty bounds; the probe loop is one table read a cycle.
//  A search finding an output transfer still pending waits before finishing.
//  Loads are accepted while a result waits. aresetn clears control and entry_count;
//  table contents are undefined until loaded.
module sorted_table_binary_search_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]    cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [63:0]                     s_axis_tdata,  // entry_index, entry_key, entry_value, search_key
    input  logic                            s_axis_tuser,  // kind
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // match_index, match_value
    output logic                            m_axis_tuser   // found
);

    stbs_pkg::stbs_cmd_t  cmd;
    stbs_pkg::stbs_stat_t stat;

    logic [stbs_pkg::IDX_W-1:0]   match_index;
    logic [stbs_pkg::VALUE_W-1:0] match_value;

    stbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_kind  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    stbs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .entry_index (s_axis_tdata[4:0]),
        .entry_key   (s_axis_tdata[20:5]),
        .entry_value (s_axis_tdata[44:21]),
        .search_key  (s_axis_tdata[60:45]),
        .cmd         (cmd),
        .stat        (stat),
        .found       (m_axis_tuser),
        .match_index (match_index),
        .match_value (match_value)
    );

    assign m_axis_tdata = {3'b000, match_value, match_index};

endmodule
